FILE: hdl/sha1_pkg.sv
// Shared types and constants for the SHA-1 hash engine.
package sha1_pkg;

    // One input word: a message byte and its flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in;

    // One output word: a digest word and its position
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    // Round registers A..E
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_work;

    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned NUM_H      = 5;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] H_INIT [NUM_H] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

FILE: hdl/sha1_round.sv
// One SHA-1 compression round, shared by all 80 rounds.
module sha1_round (
    input  sha1_pkg::t_work i_cur,
    input  logic [31:0]     i_w,
    input  logic [6:0]      i_round,
    output sha1_pkg::t_work o_nxt
);

    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] sum;

    // Pick the round function and constant by round group
    always_comb begin
        if (i_round < 7'd20) begin
            f_val = (i_cur.b & i_cur.c) | (~i_cur.b & i_cur.d);
            k_val = sha1_pkg::K0;
        end else if (i_round < 7'd40) begin
            f_val = i_cur.b ^ i_cur.c ^ i_cur.d;
            k_val = sha1_pkg::K1;
        end else if (i_round < 7'd60) begin
            f_val = (i_cur.b & i_cur.c) | (i_cur.b & i_cur.d) | (i_cur.c & i_cur.d);
            k_val = sha1_pkg::K2;
        end else begin
            f_val = i_cur.b ^ i_cur.c ^ i_cur.d;
            k_val = sha1_pkg::K3;
        end
    end

    assign sum = {i_cur.a[26:0], i_cur.a[31:27]} + f_val + i_cur.e + i_w + k_val;

    // Rotate the working registers
    assign o_nxt.a = sum;
    assign o_nxt.b = i_cur.a;
    assign o_nxt.c = {i_cur.b[1:0], i_cur.b[31:2]};
    assign o_nxt.d = i_cur.c;
    assign o_nxt.e = i_cur.d;

endmodule

FILE: hdl/sha1_hash_engine_unit.sv
// SHA-1 hash engine over a byte stream, top level.
//
// Input channel (i_valid / o_stall / i_data): each word carries an optional
// message byte and an end-of-message flag. A byte word is taken without stall
// while the 64-byte block fills; the byte that completes a block starts the
// 80-round compression, one round per cycle, then a fold of the result into
// the chaining words (S_UPDATE), and the input is stalled until both are done.
// At end of message the engine pads: word shifts into the schedule line up to
// the end of the block (at most 16 words), a compression, and the same again
// when the length field spills into a second block. The output channel
// (o_valid / i_stall / o_data) then delivers five digest words, H0 first,
// one per cycle when not stalled; a stall simply holds the current word.
// The input side is stalled throughout compression, padding and digest
// delivery. After the fifth word is taken the engine rearms. Reset returns
// the chaining words to the SHA-1 initial values, clears the byte count and
// puts the engine in the byte-accepting state.
module sha1_hash_engine_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  sha1_pkg::t_in    i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output sha1_pkg::t_out   o_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_UPDATE,
        S_PAD,
        S_OUT
    } t_state;

    t_state          r_state;
    logic [31:0]     r_h [sha1_pkg::NUM_H];
    logic [31:0]     r_line [16];
    sha1_pkg::t_work r_work;
    logic [60:0]     r_cnt;
    logic [6:0]      r_round;
    logic [23:0]     r_acc;
    logic [3:0]      r_slot;
    logic            r_fin;
    logic            r_padded;
    logic            r_lenblk;
    logic [2:0]      r_idx;
    logic            r_out_valid;
    sha1_pkg::t_out  r_out;

    logic            in_acc;
    logic [60:0]     cnt_next;
    logic [31:0]     byte_word;
    logic [31:0]     pad_word;
    logic [31:0]     pad_data;
    logic [31:0]     sched_x;
    logic [31:0]     sched_new;
    logic [31:0]     h_sum [sha1_pkg::NUM_H];
    sha1_pkg::t_work round_nxt;
    logic [1:0]      lane_gap;

    assign in_acc   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    assign cnt_next  = r_cnt + 61'd1;
    assign byte_word = {r_acc, i_data.data_byte};

    // Build the 0x80 word behind the bytes already held
    assign lane_gap = 2'd3 - r_cnt[1:0];
    assign pad_word = {r_acc, sha1_pkg::PAD_BYTE} << {lane_gap, 3'b000};

    // Select what the padding pass shifts in
    always_comb begin
        if (!r_padded) begin
            pad_data = pad_word;
        end else if (r_lenblk && r_slot == 4'd14) begin
            pad_data = r_cnt[60:29];
        end else if (r_lenblk && r_slot == 4'd15) begin
            pad_data = {r_cnt[28:0], 3'b000};
        end else begin
            pad_data = 32'd0;
        end
    end

    // Message schedule: next word from fixed taps of the line
    assign sched_x   = r_line[13] ^ r_line[8] ^ r_line[2] ^ r_line[0];
    assign sched_new = {sched_x[30:0], sched_x[31]};

    // Fold the working registers into the chaining words
    assign h_sum[0] = r_h[0] + r_work.a;
    assign h_sum[1] = r_h[1] + r_work.b;
    assign h_sum[2] = r_h[2] + r_work.c;
    assign h_sum[3] = r_h[3] + r_work.d;
    assign h_sum[4] = r_h[4] + r_work.e;

    sha1_round u_round (
        .i_cur   (r_work),
        .i_w     (r_line[0]),
        .i_round (r_round),
        .o_nxt   (round_nxt)
    );

    // Schedule line: shift on every pushed word
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc && i_data.byte_present && r_cnt[1:0] == 2'd3) begin
            for (int i = 0; i < 15; i++) r_line[i] <= r_line[i+1];
            r_line[15] <= byte_word;
        end else if (r_state == S_ROUND) begin
            for (int i = 0; i < 15; i++) r_line[i] <= r_line[i+1];
            r_line[15] <= sched_new;
        end else if (r_state == S_PAD) begin
            for (int i = 0; i < 15; i++) r_line[i] <= r_line[i+1];
            r_line[15] <= pad_data;
        end
    end

    // Byte packing register
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc && i_data.byte_present) begin
            r_acc <= byte_word[23:0];
        end
    end

    // Sequencer, chaining words and registered output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            for (int i = 0; i < sha1_pkg::NUM_H; i++) r_h[i] <= sha1_pkg::H_INIT[i];
            r_work      <= '0;
            r_cnt       <= '0;
            r_round     <= '0;
            r_slot      <= '0;
            r_fin       <= 1'b0;
            r_padded    <= 1'b0;
            r_lenblk    <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_data.byte_present) begin
                            r_cnt <= cnt_next;
                        end
                        if (i_data.byte_present && r_cnt[5:0] == 6'd63) begin
                            // block full: compress, pad afterwards if ending
                            r_state  <= S_ROUND;
                            r_work   <= '{a: r_h[0], b: r_h[1], c: r_h[2],
                                          d: r_h[3], e: r_h[4]};
                            r_round  <= '0;
                            r_fin    <= i_data.end_of_message;
                            r_padded <= 1'b0;
                            r_lenblk <= 1'b0;
                        end else if (i_data.end_of_message) begin
                            r_state  <= S_PAD;
                            r_fin    <= 1'b1;
                            r_padded <= 1'b0;
                            if (i_data.byte_present) begin
                                r_slot   <= cnt_next[5:2];
                                r_lenblk <= (cnt_next[5:0] <= 6'd55);
                            end else begin
                                r_slot   <= r_cnt[5:2];
                                r_lenblk <= (r_cnt[5:0] <= 6'd55);
                            end
                        end
                    end
                end
                S_ROUND: begin
                    r_work <= round_nxt;
                    if (r_round == 7'(sha1_pkg::NUM_ROUNDS - 1)) begin
                        r_state <= S_UPDATE;
                    end else begin
                        r_round <= r_round + 7'd1;
                    end
                end
                S_UPDATE: begin
                    for (int i = 0; i < sha1_pkg::NUM_H; i++) r_h[i] <= h_sum[i];
                    r_round <= '0;
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (r_lenblk) begin
                        // final block done: present the first digest word
                        r_state           <= S_OUT;
                        r_idx             <= '0;
                        r_out_valid       <= 1'b1;
                        r_out.digest_word <= h_sum[0];
                        r_out.word_index  <= '0;
                        r_out.last_word   <= 1'b0;
                    end else begin
                        // length did not fit: one more block
                        r_state  <= S_PAD;
                        r_slot   <= '0;
                        r_lenblk <= 1'b1;
                    end
                end
                S_PAD: begin
                    r_padded <= 1'b1;
                    r_slot   <= r_slot + 4'd1;
                    if (r_slot == 4'd15) begin
                        r_state <= S_ROUND;
                        r_work  <= '{a: r_h[0], b: r_h[1], c: r_h[2],
                                     d: r_h[3], e: r_h[4]};
                        r_round <= '0;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        if (r_idx == 3'(sha1_pkg::NUM_H - 1)) begin
                            // last word taken: rearm for the next message
                            r_state     <= S_IDLE;
                            r_out_valid <= 1'b0;
                            for (int i = 0; i < sha1_pkg::NUM_H; i++) begin
                                r_h[i] <= sha1_pkg::H_INIT[i];
                            end
                            r_cnt    <= '0;
                            r_fin    <= 1'b0;
                            r_padded <= 1'b0;
                            r_lenblk <= 1'b0;
                        end else begin
                            r_idx             <= r_idx + 3'd1;
                            r_out.digest_word <= r_h[r_idx + 3'd1];
                            r_out.word_index  <= r_idx + 3'd1;
                            r_out.last_word   <= (r_idx + 3'd1 == 3'(sha1_pkg::NUM_H - 1));
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output words appear only during digest delivery
    a_out_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == S_OUT)
        else $error("output valid outside digest delivery");

    // Round counter never runs past the last round
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROUND |-> r_round < 7'(sha1_pkg::NUM_ROUNDS))
        else $error("round counter out of range");

    // Digest delivery only after the length block is compressed
    a_out_after_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> r_fin && r_lenblk && r_padded)
        else $error("digest delivered before padding finished");

    // Taking the last word returns the engine to byte intake
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_stall && r_out.last_word |=> r_state == S_IDLE && r_cnt == '0)
        else $error("engine did not rearm after digest");

endmodule
